// ===== design/hrr_pkg.sv =====
package hrr_pkg;

    // Fixed field widths
    localparam int CH_BITS  = 8;
    localparam int HUE_BITS = 16;
    localparam int OFS_BITS = 16;

    // Divider widths: divisor is 6*d, numerator is hn*2^HUE_BITS + 3*d
    localparam int DIV_BITS = CH_BITS + 3;
    localparam int REM_BITS = DIV_BITS + 1;
    localparam int NUM_BITS = DIV_BITS + HUE_BITS;
    localparam int K_BITS   = CH_BITS + 4;

    typedef logic [CH_BITS-1:0]  ch_t;
    typedef logic [HUE_BITS-1:0] hue_t;

    typedef struct packed {
        ch_t red_in;
        ch_t green_in;
        ch_t blue_in;
    } rgb_in_t;

    typedef struct packed {
        ch_t red_out;
        ch_t green_out;
        ch_t blue_out;
    } rgb_out_t;

    // Beat carried through the divider steps
    typedef struct packed {
        logic                gray;
        rgb_in_t             raw;
        ch_t                 mx;
        ch_t                 mn;
        ch_t                 d;
        logic [DIV_BITS-1:0] div6;
        logic [NUM_BITS-1:0] num;
        logic [REM_BITS-1:0] rem;
        hue_t                quo;
    } div_item_t;

endpackage

// ===== design/hrr_div_step.sv =====
module hrr_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  hrr_pkg::div_item_t in_item,
    output logic              out_vld,
    output hrr_pkg::div_item_t out_item
);
    import hrr_pkg::*;

    logic      vld_reg;
    div_item_t item_reg;
    div_item_t item_next;
    logic [REM_BITS-1:0] part;

    // One restoring step: bring down the next numerator bit, subtract if it fits
    always_comb
    begin
        item_next = in_item;
        part = {in_item.rem[REM_BITS-2:0], in_item.num[NUM_BITS-1]};
        item_next.num = {in_item.num[NUM_BITS-2:0], 1'b0};
        if (part >= {1'b0, in_item.div6})
        begin
            item_next.rem = part - {1'b0, in_item.div6};
            item_next.quo = {in_item.quo[HUE_BITS-2:0], 1'b1};
        end
        else
        begin
            item_next.rem = part;
            item_next.quo = {in_item.quo[HUE_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ===== design/hue_rotate_rgb.sv =====
// Channel  | Signals                          | Direction
// ---------+----------------------------------+----------
// source   | src_valid, src_stall, src_data   | in beat
// result   | dst_valid, dst_stall, dst_data   | out beat
// config   | hue_offset_we, hue_offset_data   | reg write
//
// One beat per cycle unless a held result stalls the pipeline; stages are the entry stage, 27 divider
// steps, rotate stage, multiply stage and output register.
// The hue divide is a one-bit-per-stage restoring divider, 27 steps deep.
// rst_n clears all valid bits and sets hue_offset to 0.
// A stalled output freezes the whole pipeline; src_stall follows at once.
module hue_rotate_rgb (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  hrr_pkg::rgb_in_t  src_data,
    output logic              dst_valid,
    input  logic              dst_stall,
    output hrr_pkg::rgb_out_t dst_data,
    input  logic              hue_offset_we,
    input  logic [15:0]       hue_offset_data
);
    import hrr_pkg::*;

    logic en;
    logic [OFS_BITS-1:0] hue_offset_reg;

    // Pipeline moves unless a result is held
    assign en        = !(dst_valid && dst_stall);
    assign src_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hue_offset_reg <= '0;
        else if (hue_offset_we)
            hue_offset_reg <= hue_offset_data;
    end

    // Entry stage: max, min, spread, sector numerator
    ch_t r, g, b, mx, mn, d;
    logic signed [K_BITS-1:0] k;
    logic [DIV_BITS-1:0] hn;
    div_item_t e_next, e_reg;
    logic e_vld_reg;

    always_comb
    begin
        r = src_data.red_in;
        g = src_data.green_in;
        b = src_data.blue_in;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (mx == r)
            k = $signed(K_BITS'(g)) - $signed(K_BITS'(b));
        else if (mx == g)
            k = $signed(K_BITS'(d) << 1) + $signed(K_BITS'(b)) - $signed(K_BITS'(r));
        else
            k = $signed(K_BITS'(d) << 2) + $signed(K_BITS'(r)) - $signed(K_BITS'(g));
        if (k < 0)
            k = k + $signed(K_BITS'(d) * K_BITS'(6));
        hn = k[DIV_BITS-1:0];
        e_next.gray = (d == '0);
        e_next.raw  = src_data;
        e_next.mx   = mx;
        e_next.mn   = mn;
        e_next.d    = d;
        e_next.div6 = DIV_BITS'(d) * DIV_BITS'(6);
        e_next.num  = {hn, {HUE_BITS{1'b0}}} + NUM_BITS'(DIV_BITS'(d) * DIV_BITS'(3));
        e_next.rem  = '0;
        e_next.quo  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            e_reg <= e_next;
    end

    // Divider chain, one quotient bit per stage
    logic      dv_vld  [NUM_BITS+1];
    div_item_t dv_item [NUM_BITS+1];

    assign dv_vld[0]  = e_vld_reg;
    assign dv_item[0] = e_reg;

    for (genvar i = 0; i < NUM_BITS; i++)
    begin : g_div
        hrr_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (dv_vld[i]),
            .in_item  (dv_item[i]),
            .out_vld  (dv_vld[i+1]),
            .out_item (dv_item[i+1])
        );
    end

    div_item_t dq;
    assign dq = dv_item[NUM_BITS];

    // Rotate stage: add offset, split 6*H' into sector and fraction
    logic [OFS_BITS+HUE_BITS-1:0] ofs_wide;
    hue_t ofs_units, h_rot;
    logic [HUE_BITS+2:0] p;
    logic rt_vld_reg;
    logic rt_gray_reg;
    rgb_in_t rt_raw_reg;
    ch_t rt_mx_reg, rt_mn_reg, rt_d_reg;
    logic [2:0] rt_sec_reg;
    hue_t rt_f_reg;

    always_comb
    begin
        ofs_wide  = {hue_offset_reg, {HUE_BITS{1'b0}}} >> OFS_BITS;
        ofs_units = ofs_wide[HUE_BITS-1:0];
        h_rot     = dq.quo + ofs_units;
        p         = (HUE_BITS+3)'(h_rot) * (HUE_BITS+3)'(6);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_vld_reg <= 1'b0;
        else if (en)
            rt_vld_reg <= dv_vld[NUM_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_gray_reg <= dq.gray;
            rt_raw_reg  <= dq.raw;
            rt_mx_reg   <= dq.mx;
            rt_mn_reg   <= dq.mn;
            rt_d_reg    <= dq.d;
            rt_sec_reg  <= p[HUE_BITS+2:HUE_BITS];
            rt_f_reg    <= p[HUE_BITS-1:0];
        end
    end

    // Multiply stage: y = d * F
    logic ml_vld_reg;
    logic ml_gray_reg;
    rgb_in_t ml_raw_reg;
    ch_t ml_mx_reg, ml_mn_reg;
    logic [2:0] ml_sec_reg;
    logic [CH_BITS+HUE_BITS-1:0] ml_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ml_vld_reg <= 1'b0;
        else if (en)
            ml_vld_reg <= rt_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ml_gray_reg <= rt_gray_reg;
            ml_raw_reg  <= rt_raw_reg;
            ml_mx_reg   <= rt_mx_reg;
            ml_mn_reg   <= rt_mn_reg;
            ml_sec_reg  <= rt_sec_reg;
            ml_y_reg    <= (CH_BITS+HUE_BITS)'(rt_d_reg) * (CH_BITS+HUE_BITS)'(rt_f_reg);
        end
    end

    // Output stage: round q and t, pick channels by sector, pass gray colors through unchanged
    localparam int W = CH_BITS + HUE_BITS + 1;
    logic [W-1:0] q_w, t_w, half;
    ch_t q, t;
    rgb_out_t res_next;
    logic dst_valid_reg;
    rgb_out_t dst_data_reg;

    always_comb
    begin
        half = W'(1) << (HUE_BITS - 1);
        q_w  = (W'(ml_mx_reg) << HUE_BITS) - W'(ml_y_reg) + half;
        t_w  = (W'(ml_mn_reg) << HUE_BITS) + W'(ml_y_reg) + half;
        q    = q_w[HUE_BITS+CH_BITS-1:HUE_BITS];
        t    = t_w[HUE_BITS+CH_BITS-1:HUE_BITS];
        case (ml_sec_reg)
            3'd0:    res_next = '{ml_mx_reg, t, ml_mn_reg};
            3'd1:    res_next = '{q, ml_mx_reg, ml_mn_reg};
            3'd2:    res_next = '{ml_mn_reg, ml_mx_reg, t};
            3'd3:    res_next = '{ml_mn_reg, q, ml_mx_reg};
            3'd4:    res_next = '{t, ml_mn_reg, ml_mx_reg};
            default: res_next = '{ml_mx_reg, ml_mn_reg, q};
        endcase
        if (ml_gray_reg)
            res_next = '{ml_raw_reg.red_in, ml_raw_reg.green_in, ml_raw_reg.blue_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_valid_reg <= 1'b0;
        else if (en)
            dst_valid_reg <= ml_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dst_data_reg <= res_next;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

endmodule

// ===== design/hrr_check.sv =====
module hrr_check (
    input logic              clk,
    input logic              rst_n,
    input logic              src_stall,
    input logic              dst_valid,
    input logic              dst_stall,
    input hrr_pkg::rgb_out_t dst_data
);
    // Held result beat stays up
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid)
        else $error("result beat dropped while stalled");

    // Held result beat keeps its data
    a_dst_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> $stable(dst_data))
        else $error("result data changed while stalled");

    // Source is stalled only behind a held result
    a_src_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid && dst_stall)
        else $error("source stalled without a held result");

    // A held result always backs up the source
    a_src_stall_follow: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |-> src_stall)
        else $error("source taken while result held");

endmodule

bind hue_rotate_rgb hrr_check u_hrr_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hrr_pkg::*;

    localparam int LATENCY = 31;
    localparam int RANDOM_BEATS = 1150;
    localparam int CYCLE_LIMIT = 400000;

    // Predicted color for one input beat at the given hue offset
    function automatic rgb_out_t rotate_hue(rgb_in_t px, logic [15:0] ofs);
        rgb_out_t res;
        int unsigned r, g, b, mx, mn, d, hn, h, p, f, y, q, t, sector;
        int k;
        r = 32'(px.red_in);
        g = 32'(px.green_in);
        b = 32'(px.blue_in);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0)
        begin
            res.red_out = px.red_in;
            res.green_out = px.green_in;
            res.blue_out = px.blue_in;
            return res;
        end
        if (mx == r)
            k = int'(g) - int'(b);
        else if (mx == g)
            k = 2 * int'(d) + int'(b) - int'(r);
        else
            k = 4 * int'(d) + int'(r) - int'(g);
        if (k < 0)
            k += 6 * int'(d);
        hn = unsigned'(k);
        h = ((hn << HUE_BITS) + 3 * d) / (6 * d);
        h = (h + 32'(ofs)) & 32'hFFFF;
        p = 6 * h;
        sector = p >> HUE_BITS;
        f = p & 32'hFFFF;
        y = d * f;
        q = ((mx << HUE_BITS) - y + 32'h8000) >> HUE_BITS;
        t = ((mn << HUE_BITS) + y + 32'h8000) >> HUE_BITS;
        case (sector)
            0: res = '{CH_BITS'(mx), CH_BITS'(t), CH_BITS'(mn)};
            1: res = '{CH_BITS'(q), CH_BITS'(mx), CH_BITS'(mn)};
            2: res = '{CH_BITS'(mn), CH_BITS'(mx), CH_BITS'(t)};
            3: res = '{CH_BITS'(mn), CH_BITS'(q), CH_BITS'(mx)};
            4: res = '{CH_BITS'(t), CH_BITS'(mn), CH_BITS'(mx)};
            default: res = '{CH_BITS'(mx), CH_BITS'(mn), CH_BITS'(q)};
        endcase
        return res;
    endfunction

    class color_board;
        rgb_out_t pending[$];
        int errors = 0;

        function void note_input(rgb_in_t px, logic [15:0] ofs);
            pending.push_back(rotate_hue(px, ofs));
        endfunction

        function void check_result(rgb_out_t got);
            rgb_out_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.red_out !== want.red_out)
            begin
                $error("red_out expected %0d actual %0d", want.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== want.green_out)
            begin
                $error("green_out expected %0d actual %0d", want.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== want.blue_out)
            begin
                $error("blue_out expected %0d actual %0d", want.blue_out, got.blue_out);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic src_valid = 0;
    logic src_stall;
    rgb_in_t src_data = '0;
    logic dst_valid;
    logic dst_stall = 0;
    rgb_out_t dst_data;
    logic hue_offset_we = 0;
    logic [15:0] hue_offset_data = '0;

    logic [15:0] cur_offset = '0;
    bit sink_hold = 0;
    bit hold_done = 0;
    int cycles = 0;
    color_board board = new();

    hue_rotate_rgb uut (
        .clk(clk), .rst_n(rst_n),
        .src_valid(src_valid), .src_stall(src_stall), .src_data(src_data),
        .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_data(dst_data),
        .hue_offset_we(hue_offset_we), .hue_offset_data(hue_offset_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Accept monitor and cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && src_valid && !src_stall)
            board.note_input(src_data, cur_offset);
        if (rst_n && dst_valid && !dst_stall)
            board.check_result(dst_data);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver: random stall per beat, one long hold-off on request
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                dst_stall <= 1;
                repeat (120) @(negedge clk);
                hold_done = 1;
                sink_hold = 0;
                dst_stall <= 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                w = $urandom_range(0, 7);
                if (w != 0)
                begin
                    dst_stall <= 1;
                    repeat (w) @(negedge clk);
                end
                dst_stall <= 0;
            end
            else
                dst_stall <= 0;
        end
    end

    // Offer one beat; valid stays up after the accept until the next gap
    task automatic send_beat(rgb_in_t px, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 7) : 0;
        if (w != 0)
        begin
            src_valid <= 0;
            repeat (w) @(negedge clk);
        end
        src_valid <= 1;
        src_data <= px;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_rgb(int r, int g, int b);
        rgb_in_t px;
        px.red_in = CH_BITS'(r);
        px.green_in = CH_BITS'(g);
        px.blue_in = CH_BITS'(b);
        send_beat(px, 1'b0);
    endtask

    // Drain results, let the pipeline settle, then load a new hue offset
    task automatic set_offset(logic [15:0] ofs);
        int guard;
        guard = 0;
        src_valid <= 0;
        while (board.pending.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(negedge clk);
        hue_offset_we <= 1;
        hue_offset_data <= ofs;
        cur_offset = ofs;
        @(negedge clk);
        hue_offset_we <= 0;
    endtask

    function automatic rgb_in_t random_color();
        rgb_in_t px;
        int mode;
        px = 24'($urandom);
        mode = $urandom_range(0, 9);
        // some gray and tie-heavy colors
        if (mode == 0)
        begin
            px.green_in = px.red_in;
            px.blue_in = px.red_in;
        end
        else if (mode == 1)
            px.green_in = px.red_in;
        else if (mode == 2)
            px.blue_in = px.green_in;
        return px;
    endfunction

    initial
    begin
        logic [15:0] offsets[6];
        offsets = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h5555, 16'h2AAB};
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed colors at reset offset, then at full-scale offset
        for (int pass = 0; pass < 2; pass++)
        begin
            if (pass == 1)
                set_offset(16'hFFFF);
            send_rgb(0, 0, 0);
            send_rgb(255, 255, 255);
            send_rgb(128, 128, 128);
            send_rgb(255, 0, 0);
            send_rgb(0, 255, 0);
            send_rgb(0, 0, 255);
            send_rgb(255, 255, 0);
            send_rgb(0, 255, 255);
            send_rgb(255, 0, 255);
            send_rgb(255, 0, 1);
            send_rgb(1, 0, 0);
            send_rgb(255, 254, 0);
            send_rgb(200, 10, 100);
        end

        // Random phases over several offsets
        for (int ph = 0; ph < 10; ph++)
        begin
            set_offset(ph < 6 ? offsets[ph] : 16'($urandom));
            for (int i = 0; i < RANDOM_BEATS / 10; i++)
            begin
                if (ph == 3 && i == 10)
                    sink_hold = 1;
                send_beat(random_color(), (i % 50) > 10);
            end
        end

        src_valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (board.errors == 0 && hold_done)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// ===== files.f =====
design/hrr_pkg.sv
design/hrr_div_step.sv
design/hue_rotate_rgb.sv
design/hrr_check.sv
bench/tb.sv
